>>> sv/csp_pkg.sv
// Shared widths, register indexes and controller/datapath interface types
// for the compression skip predictor. No dependencies.
package csp_pkg;

	localparam int LEN_W       = 24;
	localparam int BPK_W       = 11;
	localparam int WIN_W       = 16;
	localparam int PCT_W       = 7;
	localparam int CNT_W       = 16;
	localparam int TOT_W       = CNT_W + 1;
	localparam int KB_SHIFT    = 10;
	localparam int PROD_W      = BPK_W + LEN_W;
	localparam int LIMIT_W     = PROD_W - KB_SHIFT;
	// rejected count times one hundred
	localparam int DVD_W       = CNT_W + 7;
	localparam int DIV_STEPS   = PCT_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam int IN_FIELDS_W = 1 + 2 * LEN_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 3 + PCT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [DVD_W-1:0] PCT_SCALE = DVD_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_BPK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 2'd2;

	localparam logic [BPK_W-1:0] MAX_BPK_RST = 11'd896;
	localparam logic [WIN_W-1:0] WINDOW_RST  = 16'd100;
	localparam logic [PCT_W-1:0] CUTOFF_RST  = 7'd50;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic upd;
		logic win;
		logic div_step;
		logic load_out;
	} csp_cmd_t;

	typedef struct packed {
		logic req_rec;
		logic close;
		logic div_last;
		logic out_free;
	} csp_stat_t;

endpackage

>>> sv/csp_ctrl.sv
// Sequencing controller for the compression skip predictor.
// Uses csp_pkg for the command and status structs.
module csp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  csp_pkg::csp_stat_t stat,
	output csp_pkg::csp_cmd_t  cmd
);
	import csp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_WIN  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = stat.req_rec ? ST_MUL : ST_RESP;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_WIN;
			end
			ST_WIN: begin
				cmd.win = 1'b1;
				state_d = stat.close ? ST_DIV : ST_RESP;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/csp_dpath.sv
// Datapath of the compression skip predictor: config registers, limit
// multiply, outcome counters, restoring percent divider, output register.
// Uses csp_pkg.
module csp_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  csp_pkg::csp_cmd_t                     cmd,
	output csp_pkg::csp_stat_t                    stat,
	input  logic                                  cfg_we,
	input  logic [csp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [csp_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [csp_pkg::IN_TDATA_W-1:0]        in_tdata,
	input  logic                                  in_tuser,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [csp_pkg::OUT_TDATA_W-1:0]       out_tdata
);
	import csp_pkg::*;

	logic [BPK_W-1:0]  max_bpk_q;
	logic [WIN_W-1:0]  window_q;
	logic [PCT_W-1:0]  cutoff_q;

	logic [LEN_W-1:0]  ulen_q;
	logic [LEN_W-1:0]  clen_q;
	logic [PROD_W-1:0] prod_q;

	logic [CNT_W-1:0]  rej_cnt_q;
	logic [CNT_W-1:0]  acc_cnt_q;
	logic [PCT_W-1:0]  pct_q;

	logic [DVD_W-1:0]  rem_q;
	logic [TOT_W-1:0]  divisor_q;
	logic [PCT_W-1:0]  quot_q;
	logic [STEP_W-1:0] step_q;

	logic              res_comp_q;
	logic              res_rej_q;
	logic              res_done_q;

	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              explore_in;
	logic [LEN_W-1:0]  ulen_in;
	logic [LEN_W-1:0]  clen_in;
	logic              is_rej;
	logic [TOT_W-1:0]  total;
	logic              close;
	logic [DVD_W:0]    trial;
	logic              ge;
	logic [PCT_W-1:0]  quot_next;

	assign explore_in = in_tdata[0];
	assign ulen_in    = in_tdata[LEN_W:1];
	assign clen_in    = in_tdata[2*LEN_W:LEN_W+1];

	assign is_rej = {1'b0, clen_q} > prod_q[PROD_W-1:KB_SHIFT];
	assign total  = {1'b0, rej_cnt_q} + {1'b0, acc_cnt_q};
	assign close  = (total >= {1'b0, window_q}) && (total != '0);

	// divisor aligned to the current quotient bit
	assign trial     = {{(DVD_W + 1 - TOT_W){1'b0}}, divisor_q} << step_q;
	assign ge        = {1'b0, rem_q} >= trial;
	assign quot_next = {quot_q[PCT_W-2:0], ge};

	assign stat.req_rec  = in_tuser;
	assign stat.close    = close;
	assign stat.div_last = (step_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bpk_q <= MAX_BPK_RST;
			window_q  <= WINDOW_RST;
			cutoff_q  <= CUTOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_BPK: max_bpk_q <= cfg_data[BPK_W-1:0];
				REG_WINDOW:  window_q  <= cfg_data[WIN_W-1:0];
				REG_CUTOFF:  cutoff_q  <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_cnt_q <= '0;
			acc_cnt_q <= '0;
			pct_q     <= '0;
		end else begin
			if (cmd.upd) begin
				if (is_rej) begin
					rej_cnt_q <= rej_cnt_q + 1'b1;
				end else begin
					acc_cnt_q <= acc_cnt_q + 1'b1;
				end
			end
			if (cmd.win && close) begin
				rej_cnt_q <= '0;
				acc_cnt_q <= '0;
			end
			if (cmd.div_step && (step_q == '0)) begin
				pct_q <= quot_next;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ulen_q     <= ulen_in;
			clen_q     <= clen_in;
			res_comp_q <= !in_tuser && (explore_in || (pct_q <= cutoff_q));
			res_rej_q  <= 1'b0;
			res_done_q <= 1'b0;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(max_bpk_q) * PROD_W'(ulen_q);
		end
		if (cmd.upd) begin
			res_rej_q <= is_rej;
		end
		if (cmd.win && close) begin
			rem_q      <= DVD_W'(rej_cnt_q) * PCT_SCALE;
			divisor_q  <= total;
			quot_q     <= '0;
			step_q     <= STEP_W'(DIV_STEPS - 1);
			res_done_q <= 1'b1;
		end
		if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - trial[DVD_W-1:0];
			end
			quot_q <= quot_next;
			step_q <= step_q - 1'b1;
		end
		if (cmd.load_out) begin
			out_data_q <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
				(cmd.div_step ? quot_next : pct_q), res_done_q, res_rej_q, res_comp_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/compression_skip_predictor.sv
// Compression skip predictor: a decide item (tuser 0) goes from acceptance
// straight to loading its result; a record item (tuser 1) first passes the
// multiply, counter update and window check, and when it closes a window also
// the 7-step restoring divider that forms the new rejection percentage. A
// result that finds the output register still full waits on m_tready. One
// item is in flight at a time; the output register lets the next item be
// accepted while a result waits on m_tready.
// Top level; instantiates csp_ctrl and csp_dpath, uses csp_pkg.
module compression_skip_predictor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [csp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [csp_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// explore [0], uncompressed_len [24:1], compressed_len [48:25], zero pad
	input  logic [csp_pkg::IN_TDATA_W-1:0]        s_tdata,
	// req_type [0]
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// compress_now [0], rejected [1], window_done [2], prediction [9:3], zero pad
	output logic [csp_pkg::OUT_TDATA_W-1:0]       m_tdata
);
	import csp_pkg::*;

	csp_cmd_t  cmd;
	csp_stat_t stat;

	csp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	csp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_tdata (m_tdata)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready while an item is in flight");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:3] <= 7'd100))
		else $error("prediction above one hundred");

	a_record_no_compress: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1] || m_tdata[2]) |-> !m_tdata[0])
		else $error("record result carries compress_now");
`endif

endmodule

>>> test/compression_skip_predictor_test.sv
// Self-checking testbench for compression_skip_predictor: directed decide/record
// items, then random traffic under changing register settings, random idling.
// Depends on csp_pkg and the compression_skip_predictor RTL.
module compression_skip_predictor_test;
	import csp_pkg::*;

	localparam bit REQ_DECIDE = 1'b0;
	localparam bit REQ_RECORD = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam bit [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		bit [PCT_W-1:0] prediction;
		bit             window_done;
		bit             rejected;
		bit             compress_now;
	} verdict_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	// explore [0], uncompressed_len [24:1], compressed_len [48:25], zero pad
	logic [IN_TDATA_W-1:0] s_tdata;
	// req_type [0]
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// compress_now [0], rejected [1], window_done [2], prediction [9:3], zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;

	// predictor copy of the registers and learning state
	bit [BPK_W-1:0] bpk_reg;
	bit [WIN_W-1:0] window_reg;
	bit [PCT_W-1:0] cutoff_reg;
	bit [CNT_W-1:0] rej_cnt;
	bit [CNT_W-1:0] acc_cnt;
	bit [PCT_W-1:0] reject_pct;

	verdict_t verdict_q[$];
	verdict_t want;
	int       fail_count;
	int       cycles;
	int       burst_left;
	bit       gaps_on;

	compression_skip_predictor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic verdict_t predict_verdict(bit is_record, bit explore,
			bit [LEN_W-1:0] ulen, bit [LEN_W-1:0] clen);
		verdict_t v;
		bit [63:0] lim;
		bit [31:0] total;
		v = '0;
		if (is_record == REQ_DECIDE) begin
			v.compress_now = explore || (reject_pct <= cutoff_reg);
		end else begin
			lim = (64'(bpk_reg) * 64'(ulen)) >> KB_SHIFT;
			if (64'(clen) > lim) begin
				v.rejected = 1'b1;
				rej_cnt = rej_cnt + 1'b1;
			end else begin
				acc_cnt = acc_cnt + 1'b1;
			end
			total = 32'(rej_cnt) + 32'(acc_cnt);
			if (total >= 32'(window_reg) && total != 0) begin
				reject_pct = PCT_W'((32'(rej_cnt) * 100) / total);
				rej_cnt = '0;
				acc_cnt = '0;
				v.window_done = 1'b1;
			end
		end
		v.prediction = reject_pct;
		return v;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result item: tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[0] !== want.compress_now) begin
					$error("compress_now: expected %0d, got %0d", want.compress_now, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[1] !== want.rejected) begin
					$error("rejected: expected %0d, got %0d", want.rejected, m_tdata[1]);
					fail_count++;
				end
				if (m_tdata[2] !== want.window_done) begin
					$error("window_done: expected %0d, got %0d", want.window_done, m_tdata[2]);
					fail_count++;
				end
				if (m_tdata[9:3] !== want.prediction) begin
					$error("prediction: expected %0d, got %0d", want.prediction, m_tdata[9:3]);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls: stretches of always-ready, coin-flip, mostly-stalled, mostly-ready
	initial begin
		int mode;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(10, 60)) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				repeat ($urandom_range(0, 14)) @(negedge clk) s_tvalid <= 1'b0;
			end
		end
		burst_left--;
	endtask

	task automatic send_item(bit is_record, bit explore, bit [LEN_W-1:0] ulen,
			bit [LEN_W-1:0] clen);
		pace();
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= is_record;
		s_tdata  <= IN_TDATA_W'({clen, ulen, explore});
		do @(posedge clk); while (!s_tready);
		verdict_q.push_back(predict_verdict(is_record, explore, ulen, clen));
	endtask

	// stop sending and wait for every pending result
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk) cfg_we <= 1'b0;
		case (idx)
			REG_MAX_BPK: bpk_reg    = data[BPK_W-1:0];
			REG_WINDOW:  window_reg = data[WIN_W-1:0];
			REG_CUTOFF:  cutoff_reg = data[PCT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_reset_defaults();
		send_item(REQ_DECIDE, 1'b0, 24'd0, 24'd0);
		send_item(REQ_DECIDE, 1'b1, 24'd0, 24'd0);
		// 896/1024 of 1024 bytes is exactly the limit
		send_item(REQ_RECORD, 1'b0, 24'd1024, 24'd896);
		send_item(REQ_RECORD, 1'b0, 24'd1024, 24'd897);
	endtask

	task automatic test_field_extremes();
		send_item(REQ_RECORD, 1'b1, LEN_MAX, LEN_MAX);
		send_item(REQ_RECORD, 1'b0, 24'd0, 24'd0);
		send_item(REQ_RECORD, 1'b1, 24'd0, 24'd1);
		send_item(REQ_RECORD, 1'b0, LEN_MAX, 24'd0);
		drain();
	endtask

	task automatic test_window_extremes();
		cfg_write(REG_WINDOW, 16'hFFFF);
		send_item(REQ_RECORD, 1'b0, 24'd100, 24'd1);
		send_item(REQ_RECORD, 1'b0, 24'd100, 24'd100);
		drain();
		cfg_write(REG_WINDOW, 16'd1);
		send_item(REQ_RECORD, 1'b0, 24'd100, 24'd100);
		drain();
		// zero window closes on every record
		cfg_write(REG_WINDOW, 16'd0);
		send_item(REQ_RECORD, 1'b0, 24'd100, 24'd1);
		send_item(REQ_RECORD, 1'b0, 24'd100, 24'd100);
		drain();
	endtask

	task automatic test_cutoff_extremes();
		cfg_write(REG_WINDOW, 16'd2);
		send_item(REQ_RECORD, 1'b0, 24'd0, 24'd1);
		send_item(REQ_RECORD, 1'b0, 24'd0, 24'd1);
		send_item(REQ_DECIDE, 1'b0, 24'd0, 24'd0);
		send_item(REQ_DECIDE, 1'b1, 24'd0, 24'd0);
		drain();
		cfg_write(REG_CUTOFF, 16'd100);
		send_item(REQ_DECIDE, 1'b0, 24'd0, 24'd0);
		drain();
		// above one hundred: always compress
		cfg_write(REG_CUTOFF, 16'd127);
		send_item(REQ_DECIDE, 1'b0, 24'd0, 24'd0);
		drain();
		cfg_write(REG_CUTOFF, 16'd0);
		send_item(REQ_DECIDE, 1'b0, 24'd0, 24'd0);
		drain();
	endtask

	task automatic test_ratio_extremes();
		cfg_write(REG_MAX_BPK, 16'd0);
		send_item(REQ_RECORD, 1'b0, LEN_MAX, 24'd0);
		send_item(REQ_RECORD, 1'b0, LEN_MAX, 24'd1);
		drain();
		// ratio above 1024 lets any length through
		cfg_write(REG_MAX_BPK, 16'd2047);
		send_item(REQ_RECORD, 1'b0, LEN_MAX, LEN_MAX);
		drain();
		cfg_write(REG_MAX_BPK, 16'd1024);
		send_item(REQ_RECORD, 1'b0, 24'h5A5A5A, 24'h5A5A5A);
		send_item(REQ_RECORD, 1'b0, 24'h5A5A5A, 24'h5A5A5B);
		drain();
	endtask

	task automatic test_unknown_register();
		cfg_write(REG_UNUSED, 16'($urandom()));
		send_item(REQ_DECIDE, 1'b0, 24'd0, 24'd0);
		send_item(REQ_RECORD, 1'b0, 24'd1024, 24'd1000);
		drain();
	endtask

	task automatic test_random_traffic();
		bit [LEN_W-1:0] ulen;
		bit [LEN_W-1:0] clen;
		bit [63:0]      lim;
		bit [BPK_W-1:0] bpk;
		bit [WIN_W-1:0] win;
		bit [PCT_W-1:0] cut;
		longint         near;
		for (int phase = 0; phase < 8; phase++) begin
			drain();
			case ($urandom_range(0, 7))
				0: bpk = 11'd0;
				1: bpk = 11'd1024;
				2: bpk = 11'd2047;
				3, 4, 5: bpk = BPK_W'($urandom_range(700, 1100));
				default: bpk = BPK_W'($urandom());
			endcase
			case ($urandom_range(0, 7))
				0: win = 16'd0;
				1: win = 16'd1;
				6: win = WIN_W'($urandom_range(13, 60));
				7: win = 16'hFFFF;
				default: win = WIN_W'($urandom_range(2, 12));
			endcase
			case ($urandom_range(0, 4))
				0: cut = 7'd0;
				1: cut = 7'd100;
				2: cut = 7'd127;
				default: cut = PCT_W'($urandom());
			endcase
			// upper data bits beyond each register are don't-care
			cfg_write(REG_MAX_BPK, {5'($urandom()), bpk});
			cfg_write(REG_WINDOW, win);
			cfg_write(REG_CUTOFF, {9'($urandom()), cut});
			gaps_on = (phase % 3 != 2);
			repeat (240) begin
				case ($urandom_range(0, 3))
					0: ulen = LEN_W'($urandom());
					1: ulen = LEN_W'($urandom_range(0, 4096));
					2: ulen = LEN_MAX - LEN_W'($urandom_range(0, 4096));
					default: ulen = LEN_W'($urandom_range(0, 65535));
				endcase
				lim = (64'(bpk_reg) * 64'(ulen)) >> KB_SHIFT;
				if ($urandom_range(0, 3) == 0 || lim > 64'(LEN_MAX)) begin
					clen = LEN_W'($urandom());
				end else begin
					near = longint'(lim) + $urandom_range(0, 8) - 4;
					if (near < 0)
						near = 0;
					if (near > longint'(LEN_MAX))
						near = longint'(LEN_MAX);
					clen = LEN_W'(near);
				end
				send_item(($urandom_range(0, 9) < 7) ? REQ_RECORD : REQ_DECIDE,
					1'($urandom_range(0, 1)), ulen, clen);
			end
		end
		drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		fail_count = 0;
		cycles     = 0;
		burst_left = 0;
		gaps_on    = 1'b1;
		bpk_reg    = MAX_BPK_RST;
		window_reg = WINDOW_RST;
		cutoff_reg = CUTOFF_RST;
		rej_cnt    = '0;
		acc_cnt    = '0;
		reject_pct = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_window_extremes();
		test_cutoff_extremes();
		test_ratio_extremes();
		test_unknown_register();
		test_random_traffic();

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
